FILE: hw/rtl/palri_pkg.sv
package palri_pkg;

  // command codes
  localparam logic [1:0] CMD_WRITE  = 2'd0;
  localparam logic [1:0] CMD_READ   = 2'd1;
  localparam logic [1:0] CMD_LOOKUP = 2'd2;

  // intensity register bytes
  localparam logic [11:0] INT_HI_ADDR = 12'h07f;
  localparam logic [11:0] INT_LO_ADDR = 12'h0ff;

  // base addresses of the colour groups (high byte, low byte)
  localparam logic [11:0] SPR_HI_BASE = 12'h000;
  localparam logic [11:0] SPR_LO_BASE = 12'h080;
  localparam logic [11:0] BG0_HI_BASE = 12'h400;
  localparam logic [11:0] BG0_LO_BASE = 12'h800;
  localparam logic [11:0] BG1_HI_BASE = 12'h500;
  localparam logic [11:0] BG1_LO_BASE = 12'h900;
  localparam logic [11:0] TXT_HI_BASE = 12'h700;
  localparam logic [11:0] TXT_LO_BASE = 12'hb00;

  // first colour of each group
  localparam logic [9:0] BG0_FIRST = 10'd128;
  localparam logic [9:0] BG1_FIRST = 10'd384;
  localparam logic [9:0] TXT_FIRST = 10'd640;

  // colour index decode result
  typedef struct packed {
    logic [11:0] hi_addr;
    logic [11:0] lo_addr;
    logic        hit;
    logic        bg0;
  } map_t;

endpackage

FILE: hw/rtl/palri_ram.sv
module palri_ram import palri_pkg::*; #(
  parameter int DEPTH  = 3072,
  parameter int ADDR_W = 12
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr_a,
  input  logic [ADDR_W-1:0] rd_addr_b,
  output logic [7:0]        rd_data_a,
  output logic [7:0]        rd_data_b
);

  logic [7:0] mem [DEPTH];

  // one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // two registered read ports
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

FILE: hw/rtl/palri_map.sv
module palri_map import palri_pkg::*; (
  input  logic [9:0] color_index,
  output map_t       map
);

  logic [11:0] idx;

  assign idx = {2'b00, color_index};

  // colour index to byte pair
  always_comb begin
    map = '0;
    if (color_index < 10'd127) begin
      map.hi_addr = SPR_HI_BASE + idx;
      map.lo_addr = SPR_LO_BASE + idx;
      map.hit     = 1'b1;
    end else if (color_index inside {[BG0_FIRST:BG1_FIRST - 10'd1]}) begin
      map.hi_addr = BG0_HI_BASE + idx - {2'b00, BG0_FIRST};
      map.lo_addr = BG0_LO_BASE + idx - {2'b00, BG0_FIRST};
      map.hit     = 1'b1;
      map.bg0     = 1'b1;
    end else if (color_index inside {[BG1_FIRST:TXT_FIRST - 10'd1]}) begin
      map.hi_addr = BG1_HI_BASE + idx - {2'b00, BG1_FIRST};
      map.lo_addr = BG1_LO_BASE + idx - {2'b00, BG1_FIRST};
      map.hit     = 1'b1;
    end else if (color_index inside {[TXT_FIRST:10'd895]}) begin
      map.hi_addr = TXT_HI_BASE + idx - {2'b00, TXT_FIRST};
      map.lo_addr = TXT_LO_BASE + idx - {2'b00, TXT_FIRST};
      map.hit     = 1'b1;
    end
  end

endmodule

FILE: hw/rtl/palri_shade.sv
module palri_shade import palri_pkg::*; (
  input  logic [7:0]  hi_byte,
  input  logic [7:0]  lo_byte,
  input  logic [11:0] intensity,
  input  logic        hit,
  input  logic        bg0,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue
);

  logic [3:0] nr, ng, nb;
  logic [3:0] kr, kg, kb;

  // intensity applies to the first background layer only
  assign kr = bg0 ? intensity[11:8] : 4'd0;
  assign kg = bg0 ? intensity[7:4]  : 4'd0;
  assign kb = bg0 ? intensity[3:0]  : 4'd0;

  // reduce with floor at zero
  assign nr = (hi_byte[7:4] > kr) ? hi_byte[7:4] - kr : 4'd0;
  assign ng = (hi_byte[3:0] > kg) ? hi_byte[3:0] - kg : 4'd0;
  assign nb = (lo_byte[7:4] > kb) ? lo_byte[7:4] - kb : 4'd0;

  // widen nibble to 8 bits, black on a miss
  assign red   = hit ? {nr, nr} : 8'd0;
  assign green = hit ? {ng, ng} : 8'd0;
  assign blue  = hit ? {nb, nb} : 8'd0;

endmodule

FILE: hw/rtl/palette_ram_with_bg_intensity_unit.sv
// channel | direction | handshake           | word
// input   | in        | in_valid / in_stall | command, byte_address, write_byte, color_index
// output  | out       | out_valid/out_stall | read_byte, red, green, blue, color_valid
//
// One word per cycle sustained while the output is not stalled; a word's result passes
// the read stage and then the output register. The palette memory reads both colour
// bytes in the same cycle through two read ports. After reset a clearing pass zeroes
// every memory byte, one byte a cycle; in_stall stays high until it ends.
// A stalled output word holds the read stage, and in_stall rises behind it.
module palette_ram_with_bg_intensity_unit import palri_pkg::*; #(
  parameter int PALETTE_BYTES = 3072
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [11:0] byte_address,
  input  logic [7:0]  write_byte,
  input  logic [9:0]  color_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  read_byte,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic        color_valid
);

  localparam int ADDR_W = $clog2(PALETTE_BYTES);
  localparam logic [12:0] DEPTH_LIM = 13'(PALETTE_BYTES);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PALETTE_BYTES - 1);

  localparam logic ST_CLEAR = 1'b0;
  localparam logic ST_RUN   = 1'b1;

  logic              state;
  logic [ADDR_W-1:0] clr_cnt;
  logic              accept;
  logic              in_range;
  map_t              map;

  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [7:0]        wr_data;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [7:0]        rd_data_a;
  logic [7:0]        rd_data_b;

  logic [7:0]        int_hi;
  logic [3:0]        int_lo;

  logic              s1_valid;
  logic [1:0]        s1_cmd;
  logic              s1_in_range;
  logic              s1_hit;
  logic              s1_bg0;
  logic              s1_adv;

  logic [7:0]        sh_red, sh_green, sh_blue;
  logic              lookup_hit;

  // handshake
  assign s1_adv   = s1_valid && (!out_valid || !out_stall);
  assign in_stall = (state == ST_CLEAR) || (s1_valid && !s1_adv);
  assign accept   = in_valid && !in_stall;
  assign in_range = {1'b0, byte_address} < DEPTH_LIM;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
    end else if (state == ST_CLEAR) begin
      clr_cnt <= clr_cnt + ADDR_W'(1);
      if (clr_cnt == LAST_ADDR) begin
        state <= ST_RUN;
      end
    end
  end

  // memory port muxing
  always_comb begin
    if (state == ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = 8'd0;
    end else begin
      wr_en   = accept && (command == CMD_WRITE) && in_range;
      wr_addr = ADDR_W'(byte_address);
      wr_data = write_byte;
    end
  end

  assign rd_addr_a = (command == CMD_LOOKUP) ? ADDR_W'(map.hi_addr) : ADDR_W'(byte_address);

  palri_map u_map (
    .color_index (color_index),
    .map         (map)
  );

  palri_ram #(
    .DEPTH  (PALETTE_BYTES),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_en     (accept),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (ADDR_W'(map.lo_addr)),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  // background intensity shadow of bytes 0x07f and 0x0ff
  always_ff @(posedge clk) begin
    if (rst) begin
      int_hi <= 8'd0;
      int_lo <= 4'd0;
    end else if (accept && command == CMD_WRITE) begin
      if (byte_address == INT_HI_ADDR) begin
        int_hi <= write_byte;
      end
      if (byte_address == INT_LO_ADDR) begin
        int_lo <= write_byte[7:4];
      end
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd      <= command;
      s1_in_range <= in_range;
      s1_hit      <= map.hit;
      s1_bg0      <= map.bg0;
    end
  end

  assign lookup_hit = (s1_cmd == CMD_LOOKUP) && s1_hit;

  palri_shade u_shade (
    .hi_byte   (rd_data_a),
    .lo_byte   (rd_data_b),
    .intensity ({int_hi, int_lo}),
    .hit       (lookup_hit),
    .bg0       (s1_bg0),
    .red       (sh_red),
    .green     (sh_green),
    .blue      (sh_blue)
  );

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output word
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      read_byte   <= (s1_cmd == CMD_READ && s1_in_range) ? rd_data_a : 8'd0;
      red         <= sh_red;
      green       <= sh_green;
      blue        <= sh_blue;
      color_valid <= lookup_hit;
    end
  end

endmodule

FILE: test/tb.sv
`timescale 1ns / 100ps

module tb;
  import palri_pkg::*;

  localparam int          PAL_SIZE    = 3072;
  localparam logic [1:0]  CMD_NONE    = 2'd3;
  localparam logic [9:0]  INT_COLOR   = 10'd127;
  localparam logic [9:0]  COLOR_END   = 10'd896;
  localparam int          RAND_ITEMS  = 400;
  localparam int          CALM_TAIL   = 60;
  localparam int          DRAIN_EVERY = 150;
  localparam int          HOLD_AFTER  = 100;
  localparam int          HOLD_LEN    = 250;
  localparam int          STALL_LIMIT = 20000;

  typedef struct {
    logic [1:0]  command;
    logic [11:0] byte_address;
    logic [7:0]  write_byte;
    logic [9:0]  color_index;
    bit          drain_first;
  } palette_cmd_t;

  typedef struct {
    logic [7:0] read_byte;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       color_valid;
  } palette_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  command = '0;
  logic [11:0] byte_address = '0;
  logic [7:0]  write_byte = '0;
  logic [9:0]  color_index = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  read_byte;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        color_valid;

  // shadow copy of the palette and intensity register
  logic [7:0]  shadow_ram [0:PAL_SIZE-1];
  logic [11:0] shadow_int;

  palette_cmd_t cmd_queue[$];
  palette_out_t due_words[$];

  int total_cmds;
  int accepted;
  int results_seen;
  int mismatches;
  int gap_left;
  int stall_left;
  int n_writes, n_reads, n_lookups, n_hits, n_unused;
  int hold_left;
  int words_out;
  bit hold_done;
  int idle_cycles;

  palette_ram_with_bg_intensity_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .byte_address(byte_address),
    .write_byte  (write_byte),
    .color_index (color_index),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .read_byte   (read_byte),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .color_valid (color_valid)
  );

  always #5 clk = ~clk;

  // where a colour's two bytes live; returns 0 for unmapped colours
  function automatic logic color_home(input logic [9:0] c, output logic [11:0] hi,
                                      output logic [11:0] lo, output logic bg0);
    logic hit;
    hit = 1'b1;
    hi = '0;
    lo = '0;
    bg0 = 1'b0;
    if (c < INT_COLOR) begin
      hi = SPR_HI_BASE + 12'(c);
      lo = SPR_LO_BASE + 12'(c);
    end else if (c >= BG0_FIRST && c < BG1_FIRST) begin
      hi = BG0_HI_BASE + 12'(c - BG0_FIRST);
      lo = BG0_LO_BASE + 12'(c - BG0_FIRST);
      bg0 = 1'b1;
    end else if (c >= BG1_FIRST && c < TXT_FIRST) begin
      hi = BG1_HI_BASE + 12'(c - BG1_FIRST);
      lo = BG1_LO_BASE + 12'(c - BG1_FIRST);
    end else if (c >= TXT_FIRST && c < COLOR_END) begin
      hi = TXT_HI_BASE + 12'(c - TXT_FIRST);
      lo = TXT_LO_BASE + 12'(c - TXT_FIRST);
    end else begin
      hit = 1'b0;
    end
    return hit;
  endfunction

  // level minus intensity, floored at zero
  function automatic logic [3:0] dim(input logic [3:0] n, input logic [3:0] k);
    return (n > k) ? n - k : 4'd0;
  endfunction

  // applies one word to the shadow state and returns the result it yields
  function automatic palette_out_t palette_predict(input palette_cmd_t c);
    palette_out_t o;
    logic [11:0]  hi_a, lo_a;
    logic         bg0;
    logic [3:0]   nr, ng, nb;
    o = '{default: '0};
    case (c.command)
      CMD_WRITE: begin
        n_writes++;
        if (c.byte_address < PAL_SIZE) begin
          shadow_ram[c.byte_address] = c.write_byte;
          if (c.byte_address == INT_HI_ADDR || c.byte_address == INT_LO_ADDR)
            shadow_int = {shadow_ram[INT_HI_ADDR], shadow_ram[INT_LO_ADDR][7:4]};
        end
      end
      CMD_READ: begin
        n_reads++;
        if (c.byte_address < PAL_SIZE) o.read_byte = shadow_ram[c.byte_address];
      end
      CMD_LOOKUP: begin
        n_lookups++;
        o.color_valid = color_home(c.color_index, hi_a, lo_a, bg0);
        if (o.color_valid) begin
          n_hits++;
          nr = shadow_ram[hi_a][7:4];
          ng = shadow_ram[hi_a][3:0];
          nb = shadow_ram[lo_a][7:4];
          if (bg0) begin
            nr = dim(nr, shadow_int[11:8]);
            ng = dim(ng, shadow_int[7:4]);
            nb = dim(nb, shadow_int[3:0]);
          end
          o.red = {nr, nr};
          o.green = {ng, ng};
          o.blue = {nb, nb};
        end
      end
      default: n_unused++;
    endcase
    return o;
  endfunction

  // fields the command ignores get random values
  task automatic queue_cmd(input logic [1:0] cmd, input logic [11:0] a,
                           input logic [7:0] d, input logic [9:0] ci);
    palette_cmd_t item;
    item.command = cmd;
    item.byte_address = a;
    item.write_byte = d;
    item.color_index = ci;
    if (cmd == CMD_WRITE || cmd == CMD_READ) item.color_index = 10'($urandom);
    if (cmd == CMD_READ || cmd == CMD_LOOKUP) item.write_byte = 8'($urandom);
    if (cmd == CMD_LOOKUP) item.byte_address = 12'($urandom);
    item.drain_first = (cmd_queue.size() % DRAIN_EVERY == 0) && (cmd_queue.size() != 0);
    cmd_queue.push_back(item);
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch at result %0d: %s got %0h want %0h", results_seen, what, got, want);
  endtask

  // driver: offers queued words, random gaps between them
  always @(posedge clk) begin : driver
    logic busy;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      busy = in_valid;
      if (in_valid && !in_stall) begin
        due_words.push_back(palette_predict(cmd_queue.pop_front()));
        accepted++;
        busy = 1'b0;
        if (accepted < total_cmds - CALM_TAIL && $urandom_range(0, 7) == 0)
          gap_left = $urandom_range(1, 19);
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (cmd_queue.size() > 0 &&
                     !(cmd_queue[0].drain_first && due_words.size() > 0)) begin
          command <= cmd_queue[0].command;
          byte_address <= cmd_queue[0].byte_address;
          write_byte <= cmd_queue[0].write_byte;
          color_index <= cmd_queue[0].color_index;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each result word against the oldest prediction
  always @(posedge clk) begin : receiver
    palette_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (due_words.size() == 0) begin
          report_mismatch("word with nothing expected, read_byte", read_byte, 8'd0);
        end else begin
          want = due_words.pop_front();
          if (read_byte !== want.read_byte) report_mismatch("read_byte", read_byte, want.read_byte);
          if (red !== want.red) report_mismatch("red", red, want.red);
          if (green !== want.green) report_mismatch("green", green, want.green);
          if (blue !== want.blue) report_mismatch("blue", blue, want.blue);
          if (color_valid !== want.color_valid)
            report_mismatch("color_valid", 8'(color_valid), 8'(want.color_valid));
        end
      end
      if (stall_left > 0)
        stall_left--;
      else if (results_seen < total_cmds - CALM_TAIL && $urandom_range(0, 7) == 0)
        stall_left = $urandom_range(1, 19);
      out_stall <= (stall_left > 0) || (hold_left > 0);
    end
  end

  // one long output hold-off so the pipeline backs up into in_stall
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      words_out <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) words_out <= words_out + 1;
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
      end else if (!hold_done && words_out == HOLD_AFTER) begin
        hold_left <= HOLD_LEN;
        hold_done <= 1'b1;
      end
    end
  end

  // cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int          pick;
    logic [9:0]  c;
    logic [11:0] hi, lo;
    logic        bg0;

    foreach (shadow_ram[i]) shadow_ram[i] = '0;
    shadow_int = '0;

    // directed: group edges, intensity floor, unmapped colours, bad address
    queue_cmd(CMD_WRITE, 12'h400, 8'hff, '0);
    queue_cmd(CMD_WRITE, 12'h800, 8'hf0, '0);
    queue_cmd(CMD_LOOKUP, '0, '0, 10'd128);
    queue_cmd(CMD_WRITE, INT_HI_ADDR, 8'h5a, '0);
    queue_cmd(CMD_WRITE, INT_LO_ADDR, 8'h3c, '0);
    queue_cmd(CMD_LOOKUP, '0, '0, 10'd128);
    queue_cmd(CMD_WRITE, 12'h401, 8'h21, '0);
    queue_cmd(CMD_WRITE, 12'h801, 8'h10, '0);
    queue_cmd(CMD_LOOKUP, '0, '0, 10'd129);
    queue_cmd(CMD_READ, INT_HI_ADDR, '0, '0);
    queue_cmd(CMD_READ, INT_LO_ADDR, '0, '0);
    queue_cmd(CMD_LOOKUP, '0, '0, INT_COLOR);
    queue_cmd(CMD_LOOKUP, '0, '0, COLOR_END);
    queue_cmd(CMD_WRITE, 12'h000, 8'ha5, '0);
    queue_cmd(CMD_WRITE, 12'h080, 8'h7e, '0);
    queue_cmd(CMD_LOOKUP, '0, '0, 10'd0);
    queue_cmd(CMD_WRITE, 12'h5ff, 8'h9c, '0);
    queue_cmd(CMD_WRITE, 12'h9ff, 8'hd3, '0);
    queue_cmd(CMD_LOOKUP, '0, '0, 10'd639);
    queue_cmd(CMD_WRITE, 12'h7ff, 8'h12, '0);
    queue_cmd(CMD_WRITE, 12'hbff, 8'hff, '0);
    queue_cmd(CMD_LOOKUP, '0, '0, 10'd895);
    queue_cmd(CMD_WRITE, 12'hc00, 8'hff, '0);
    queue_cmd(CMD_READ, 12'hc00, '0, '0);
    queue_cmd(CMD_READ, 12'hfff, '0, '0);
    queue_cmd(CMD_NONE, 12'hfff, 8'hff, 10'h3ff);

    // random: mostly colour updates followed by a lookup of that colour
    while (cmd_queue.size() < RAND_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        c = 10'($urandom_range(0, COLOR_END - 1));
        void'(color_home(c, hi, lo, bg0));
        queue_cmd(CMD_WRITE, hi, 8'($urandom), '0);
        queue_cmd(CMD_WRITE, lo, 8'($urandom), '0);
        queue_cmd(CMD_LOOKUP, '0, '0, c);
      end else if (pick < 38) begin
        queue_cmd(CMD_WRITE, $urandom_range(0, 1) ? INT_HI_ADDR : INT_LO_ADDR,
                  8'($urandom), '0);
      end else if (pick < 58) begin
        c = 10'(($urandom_range(0, 9) == 0) ? $urandom_range(COLOR_END, 1023)
                                            : $urandom_range(0, COLOR_END - 1));
        queue_cmd(CMD_LOOKUP, '0, '0, c);
      end else if (pick < 70) begin
        queue_cmd(CMD_READ, 12'($urandom_range(0, PAL_SIZE - 1)), '0, '0);
      end else if (pick < 80) begin
        queue_cmd(CMD_WRITE, 12'($urandom_range(0, 4095)), 8'($urandom), '0);
      end else if (pick < 92) begin
        queue_cmd(CMD_READ, 12'($urandom_range(0, 4095)), '0, '0);
      end else begin
        queue_cmd(CMD_NONE, 12'($urandom), 8'($urandom), 10'($urandom));
      end
    end
    total_cmds = cmd_queue.size();

    // reset, then the block clears its memory before taking words
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (cmd_queue.size() > 0) @(posedge clk);
    while (due_words.size() > 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("covered %0d writes, %0d reads, %0d lookups (%0d mapped), %0d unused commands",
             n_writes, n_reads, n_lookups, n_hits, n_unused);
    $display("checked %0d result words, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/palri_pkg.sv
hw/rtl/palri_ram.sv
hw/rtl/palri_map.sv
hw/rtl/palri_shade.sv
hw/rtl/palette_ram_with_bg_intensity_unit.sv
test/tb.sv
